>>> rtl/i2d_pkg.sv
// Package for the 64-bit binary to decimal ASCII converter.
// Holds request/result payload types, character codes and divider constants.
// No dependencies.
package i2d_pkg;

    localparam int MAX_DIGITS = 20;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int VALUE_W = 64;
    localparam int CHUNK_W = 16;
    localparam int NUM_CHUNKS = VALUE_W / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);

    // Partial dividend is {remainder, chunk}; remainder < 10, so 20 bits suffice
    localparam int PART_W = CHUNK_W + 4;

    // floor(x / 10) == (x * DIV_MULT) >> DIV_SHIFT for all x < 10 * 2**CHUNK_W
    localparam int DIV_SHIFT = 23;
    localparam int DIV_MULT_W = 20;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = 20'd838861;
    localparam int PROD_W = PART_W + DIV_MULT_W;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } res_t;

endpackage

>>> rtl/i2d_div_step.sv
// One step of the shared divide-by-ten unit: folds a 16-bit chunk into the
// running remainder and returns the quotient chunk and the new remainder.
// Depends on i2d_pkg.
module i2d_div_step
(
    input  logic [3:0]                   rem_in,
    input  logic [i2d_pkg::CHUNK_W-1:0]  chunk,
    output logic [i2d_pkg::CHUNK_W-1:0]  quot,
    output logic [3:0]                   rem_out
);

    logic [i2d_pkg::PART_W-1:0] part;
    logic [i2d_pkg::PROD_W-1:0] prod;
    logic [i2d_pkg::PART_W-1:0] times_ten;
    logic [i2d_pkg::PART_W-1:0] diff;

    always_comb
    begin
        part = {rem_in, chunk};
        prod = i2d_pkg::PROD_W'(part) * i2d_pkg::PROD_W'(i2d_pkg::DIV_MULT);
        // quotient fits in one chunk because rem_in < 10
        quot = prod[i2d_pkg::DIV_SHIFT +: i2d_pkg::CHUNK_W];
        times_ten = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
        diff = part - times_ten;
        rem_out = diff[3:0];
    end

endmodule

>>> rtl/int64_to_decimal_ascii.sv
// 64-bit binary to decimal ASCII converter, top level.
// The shared divide-by-ten unit works through the value one 16-bit chunk at a time, most
// significant chunk first, to produce each decimal digit; characters then follow one per cycle
// while dst_stall is low, sign first. A new request is taken only once the converter is idle again.
// Reset (rst_n, async, active low) returns to idle with no result pending.
// Depends on i2d_pkg and i2d_div_step.
module int64_to_decimal_ascii
(
    input  logic           clk,
    input  logic           rst_n,
    input  i2d_pkg::req_t  src,
    input  logic           src_valid,
    output logic           src_stall,
    output i2d_pkg::res_t  dst,
    output logic           dst_valid,
    input  logic           dst_stall
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t                                 state_reg, state_next;
    logic [i2d_pkg::VALUE_W-1:0]            quot_reg, quot_next;
    logic [3:0]                             rem_reg, rem_next;
    logic [i2d_pkg::CHUNK_IDX_W-1:0]        chunk_reg, chunk_next;
    logic [i2d_pkg::DIGIT_IDX_W-1:0]        count_reg, count_next;
    logic [i2d_pkg::DIGIT_IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                                   neg_reg, neg_next;
    logic                                   sign_pending_reg, sign_pending_next;
    logic                                   out_valid_reg, out_valid_next;
    i2d_pkg::res_t                          out_reg, out_next;

    logic [3:0] digit_store [i2d_pkg::MAX_DIGITS];

    logic [i2d_pkg::CHUNK_W-1:0]  step_chunk;
    logic [i2d_pkg::CHUNK_W-1:0]  step_quot;
    logic [3:0]                   step_rem;
    logic                         store_we;
    logic                         digit_load;
    logic                         src_take;
    logic                         out_free;
    logic                         is_neg;

    i2d_div_step u_div_step
    (
        .rem_in  (rem_reg),
        .chunk   (step_chunk),
        .quot    (step_quot),
        .rem_out (step_rem)
    );

    assign step_chunk = quot_reg[chunk_reg * i2d_pkg::CHUNK_W +: i2d_pkg::CHUNK_W];
    assign src_stall = (state_reg != ST_IDLE);
    assign src_take = src_valid && !src_stall;
    assign out_free = !out_valid_reg || !dst_stall;
    assign is_neg = src.kind && src.value[i2d_pkg::VALUE_W-1];
    assign dst = out_reg;
    assign dst_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        quot_next = quot_reg;
        rem_next = rem_reg;
        chunk_next = chunk_reg;
        count_next = count_reg;
        rd_idx_next = rd_idx_reg;
        neg_next = neg_reg;
        sign_pending_next = sign_pending_reg;
        out_valid_next = out_valid_reg && dst_stall;
        out_next = out_reg;
        store_we = 1'b0;
        digit_load = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (src_take)
                begin
                    neg_next = is_neg;
                    quot_next = is_neg ? (~src.value + 1'b1) : src.value;
                    rem_next = 4'd0;
                    chunk_next = i2d_pkg::CHUNK_IDX_W'(i2d_pkg::NUM_CHUNKS - 1);
                    count_next = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                quot_next[chunk_reg * i2d_pkg::CHUNK_W +: i2d_pkg::CHUNK_W] = step_quot;
                rem_next = step_rem;
                chunk_next = chunk_reg - 1'b1;
                if (chunk_reg == '0)
                begin
                    store_we = 1'b1;
                    rem_next = 4'd0;
                    // quot_next now holds the full quotient of this digit
                    if (quot_next == '0
                        || count_reg == i2d_pkg::DIGIT_IDX_W'(i2d_pkg::MAX_DIGITS - 1))
                    begin
                        state_next = ST_EMIT;
                        rd_idx_next = count_reg;
                        sign_pending_next = neg_reg;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_pending_reg)
                    begin
                        out_next.character = i2d_pkg::CHAR_MINUS;
                        out_next.last = 1'b0;
                        sign_pending_next = 1'b0;
                    end
                    else
                    begin
                        // digit character is read from the store in the clocked block
                        digit_load = 1'b1;
                        if (rd_idx_reg == '0)
                            state_next = ST_IDLE;
                        else
                            rd_idx_next = rd_idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            quot_reg <= '0;
            rem_reg <= '0;
            chunk_reg <= '0;
            count_reg <= '0;
            rd_idx_reg <= '0;
            neg_reg <= 1'b0;
            sign_pending_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            quot_reg <= quot_next;
            rem_reg <= rem_next;
            chunk_reg <= chunk_next;
            count_reg <= count_next;
            rd_idx_reg <= rd_idx_next;
            neg_reg <= neg_next;
            sign_pending_reg <= sign_pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (digit_load)
        begin
            out_reg.character <= i2d_pkg::CHAR_ZERO + {4'd0, digit_store[rd_idx_reg]};
            out_reg.last <= (rd_idx_reg == '0);
        end
        else
            out_reg <= out_next;
        if (store_we)
            digit_store[count_reg] <= step_rem;
    end

endmodule

>>> rtl/i2d_checker.sv
// Port-level checks for the decimal ASCII converter, bound to the top level.
// Depends on i2d_pkg and int64_to_decimal_ascii.
module i2d_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           src_valid,
    input logic           src_stall,
    input i2d_pkg::res_t  dst,
    input logic           dst_valid,
    input logic           dst_stall
);

    // a taken request sets the converter busy, so the request behind it stalls
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> src_stall)
        else $error("converter took a request right after another");

    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(dst))
        else $error("stalled result changed");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (dst.character >= i2d_pkg::CHAR_ZERO
                       && dst.character <= i2d_pkg::CHAR_ZERO + 8'd9)
                      || dst.character == i2d_pkg::CHAR_MINUS)
        else $error("result character is not a digit or minus");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst.character == i2d_pkg::CHAR_MINUS |-> !dst.last)
        else $error("minus sign flagged as last character");

    // no new request is taken while a number's text is still being sent
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_stall && !dst.last |-> src_stall)
        else $error("converter idle in the middle of a number");

endmodule

bind int64_to_decimal_ascii i2d_checker u_i2d_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .dst       (dst),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall)
);

>>> verif/tb_int64_to_decimal_ascii.sv
// Testbench for int64_to_decimal_ascii: drives 64-bit requests, predicts the decimal ASCII
// text of each one and checks every character and last flag against that text.
// Depends on i2d_pkg and the int64_to_decimal_ascii RTL.
module tb_int64_to_decimal_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_UNSIGNED = 1'b0;
    localparam logic KIND_SIGNED   = 1'b1;
    localparam int   DRAIN_CYCLES  = 120;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    i2d_pkg::req_t src = '0;
    logic src_valid = 1'b0;
    logic src_stall;
    i2d_pkg::res_t dst;
    logic dst_valid;
    logic dst_stall = 1'b0;

    i2d_pkg::req_t pending_reqs[$];
    i2d_pkg::res_t expected_chars[$];
    int   sent_cnt = 0;
    int   taken_cnt = 0;
    int   errors = 0;
    int   src_idle_pct = 0;
    int   dst_stall_pct = 0;

    int idle_by_phase[4]  = '{0, 70, 0, 8};
    int stall_by_phase[4] = '{0, 0, 70, 8};

    int64_to_decimal_ascii dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .src(src),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .dst(dst),
        .dst_valid(dst_valid),
        .dst_stall(dst_stall)
    );

    always #4 clk = ~clk;

    // Queue the decimal text of one request, sign first, most significant digit next.
    function automatic void predict_text(input i2d_pkg::req_t r);
        logic [63:0]   mag;
        logic          neg;
        logic [3:0]    digits[i2d_pkg::MAX_DIGITS];
        int            n;
        i2d_pkg::res_t c;
        neg = (r.kind == KIND_SIGNED) && r.value[63];
        mag = neg ? (~r.value + 64'd1) : r.value;
        n = 0;
        do
        begin
            digits[n] = 4'(mag % 64'd10);
            mag = mag / 64'd10;
            n++;
        end
        while (mag != 64'd0 && n < i2d_pkg::MAX_DIGITS);
        if (neg)
        begin
            c.character = i2d_pkg::CHAR_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            c.character = i2d_pkg::CHAR_ZERO + 8'(digits[i]);
            c.last = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic i2d_pkg::req_t random_request();
        i2d_pkg::req_t r;
        int            shift;
        r.kind = 1'($urandom_range(0, 1));
        r.value = {$urandom, $urandom};
        // narrow most values so that every digit count shows up
        shift = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 63);
        r.value = r.value >> shift;
        if (r.kind == KIND_SIGNED && $urandom_range(0, 1) == 1)
            r.value = ~r.value + 64'd1;
        return r;
    endfunction

    task automatic push_req(input logic kind, input logic [63:0] value);
        i2d_pkg::req_t r;
        r.kind = kind;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    // Request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            src_valid <= 1'b0;
        else if (!src_valid || taken_cnt == sent_cnt)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                src <= pending_reqs.pop_front();
                src_valid <= 1'b1;
                sent_cnt <= sent_cnt + 1;
            end
            else
                src_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        dst_stall <= ($urandom_range(0, 99) < dst_stall_pct);
    end

    // Request acceptance and result checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
            begin
                predict_text(src);
                taken_cnt <= taken_cnt + 1;
            end
            if (dst_valid && !dst_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected character expected none actual %h last %b",
                             $time, dst.character, dst.last);
                    errors++;
                end
                else
                begin
                    i2d_pkg::res_t exp_c;
                    exp_c = expected_chars.pop_front();
                    if (dst.character !== exp_c.character)
                    begin
                        $display("%0t: character mismatch expected %h actual %h",
                                 $time, exp_c.character, dst.character);
                        errors++;
                    end
                    if (dst.last !== exp_c.last)
                    begin
                        $display("%0t: last mismatch expected %b actual %b",
                                 $time, exp_c.last, dst.last);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct = idle_by_phase[p];
            dst_stall_pct = stall_by_phase[p];
            if (p == 0)
            begin
                push_req(KIND_UNSIGNED, 64'd0);
                push_req(KIND_SIGNED, 64'd0);
                push_req(KIND_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
                push_req(KIND_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
                push_req(KIND_SIGNED, 64'h8000_0000_0000_0000);
                push_req(KIND_UNSIGNED, 64'h8000_0000_0000_0000);
                push_req(KIND_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
                push_req(KIND_UNSIGNED, 64'd1);
                push_req(KIND_UNSIGNED, 64'd9);
                push_req(KIND_UNSIGNED, 64'd10);
                push_req(KIND_SIGNED, 64'd99);
                push_req(KIND_UNSIGNED, 64'd100);
                push_req(KIND_UNSIGNED, 64'd10000000000000000000);
                push_req(KIND_UNSIGNED, 64'd9999999999999999999);
                push_req(KIND_SIGNED, 64'd12345);
                push_req(KIND_SIGNED, -64'sd9);
                push_req(KIND_SIGNED, -64'sd10);
                push_req(KIND_SIGNED, -64'sd1000000000000000000);
                push_req(KIND_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA);
                push_req(KIND_SIGNED, 64'h5555_5555_5555_5555);
            end
            repeat (50) pending_reqs.push_back(random_request());
            // hold off new requests until every character of this phase is back
            do
                @(posedge clk);
            while (pending_reqs.size() != 0 || taken_cnt != sent_cnt
                   || expected_chars.size() != 0);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_chars.size() != 0)
        begin
            $display("%0t: %0d characters never arrived", $time, expected_chars.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("FAIL");
        $finish;
    end

endmodule
